[design/cslex_pkg.sv]
// ----------------------------------------------------------------------------
// cslex_pkg: shared definitions of the C subset lexical scanner
// Token class codes, scan mode codes, keyword table, result word layout and
// the character classification helpers used by the scanner.
// ----------------------------------------------------------------------------
package cslex_pkg;

  localparam int unsigned MaxTokenLenDefault = 20;
  localparam int unsigned NumberWidthDefault = 32;

  localparam int unsigned KwChars = 6;
  localparam int unsigned KwCount = 7;

  localparam logic [5:0] ClsIdent   = 6'd7;
  localparam logic [5:0] ClsNumber  = 6'd8;
  localparam logic [5:0] ClsInvalid = 6'd34;

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeIdent  = 2'd1;
  localparam logic [1:0] ModeNumber = 2'd2;
  localparam logic [1:0] ModeOper   = 2'd3;

  localparam logic [7:0] KwText [KwCount][KwChars] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00}
  };
  localparam logic [2:0] KwLen [KwCount] = '{3'd2, 3'd5, 3'd6, 3'd4, 3'd3, 3'd5, 3'd4};

  typedef struct packed {
    logic [5:0]  token_class;
    logic [31:0] number_value;
    logic [4:0]  token_length;
    logic        overflow;
    logic        last_of_run;
  } cslex_res_t;

  typedef struct packed {
    cslex_res_t res0;
    cslex_res_t res1;
    logic       two;
  } cslex_pair_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic two_capable(logic [7:0] c);
    return c inside {">", "<", "|", "&", "=", "!"};
  endfunction

  function automatic logic oper_pairs(logic [7:0] first, logic [7:0] second);
    logic hit;
    if (first == "|" || first == "&") begin
      hit = (second == first);
    end else begin
      hit = (second == "=");
    end
    return hit;
  endfunction

  function automatic logic [5:0] oper_single(logic [7:0] c);
    logic [5:0] cls;
    case (c)
      ">": cls = 6'd9;
      "<": cls = 6'd11;
      "|": cls = 6'd13;
      "&": cls = 6'd15;
      "+": cls = 6'd17;
      "-": cls = 6'd18;
      "*": cls = 6'd19;
      "/": cls = 6'd20;
      "=": cls = 6'd21;
      ";": cls = 6'd23;
      "(": cls = 6'd24;
      ")": cls = 6'd25;
      "{": cls = 6'd26;
      "}": cls = 6'd27;
      "$": cls = 6'd28;
      "#": cls = 6'd29;
      "!": cls = 6'd30;
      ".": cls = 6'd32;
      ",": cls = 6'd33;
      default: cls = ClsInvalid;
    endcase
    return cls;
  endfunction

endpackage

[design/cslex_step.sv]
// ----------------------------------------------------------------------------
// cslex_step: next-state and result logic of the scanner
// Given the current scan state and one character, computes the next state,
// the keyword buffer write and up to two result words.
// ----------------------------------------------------------------------------
module cslex_step #(
  parameter int unsigned MAX_TOKEN_LEN = cslex_pkg::MaxTokenLenDefault,
  parameter int unsigned NUMBER_WIDTH  = cslex_pkg::NumberWidthDefault,
  localparam int unsigned LenW         = $clog2(MAX_TOKEN_LEN)
) (
  input  logic [7:0]              char_i,
  input  logic [1:0]              mode_i,
  input  logic [LenW-1:0]         len_i,
  input  logic [NUMBER_WIDTH-1:0] acc_i,
  input  logic                    ovf_i,
  input  logic [7:0]              pend_i,
  input  logic [7:0]              kw_i [cslex_pkg::KwChars],
  output logic [1:0]              mode_o,
  output logic [LenW-1:0]         len_o,
  output logic [NUMBER_WIDTH-1:0] acc_o,
  output logic                    ovf_o,
  output logic [7:0]              pend_o,
  output logic                    kw_we_o,
  output logic [2:0]              kw_idx_o,
  output logic                    pair_valid_o,
  output cslex_pkg::cslex_pair_t  pair_o
);
  import cslex_pkg::*;

  localparam int unsigned ProdW = NUMBER_WIDTH + 4;

  logic             let_c, dig_c, len_room;
  logic [3:0]       digit;
  logic [ProdW-1:0] acc_ext, prod;
  logic [63:0]      value_ext;
  logic [7:0]       len_ext;
  logic [6:0]       kw_hit;
  logic [5:0]       ident_cls;
  logic             a_v, b_v;
  cslex_res_t       res_a, res_b;

  assign let_c     = is_letter(char_i);
  assign dig_c     = is_digit(char_i);
  assign digit     = 4'(char_i - 8'h30);
  assign len_room  = len_i < LenW'(MAX_TOKEN_LEN - 1);
  assign acc_ext   = ProdW'(acc_i);
  assign prod      = (acc_ext << 3) + (acc_ext << 1) + ProdW'(digit);
  assign value_ext = 64'(acc_i);
  assign len_ext   = 8'(len_i);

  always_comb begin
    for (int n = 0; n < KwCount; n++) begin
      kw_hit[n] = !ovf_i && (len_i == LenW'(KwLen[n]));
      for (int i = 0; i < KwChars; i++) begin
        if (i < int'(KwLen[n]) && kw_i[i] != KwText[n][i]) begin
          kw_hit[n] = 1'b0;
        end
      end
    end
    ident_cls = ClsIdent;
    for (int n = KwCount - 1; n >= 0; n--) begin
      if (kw_hit[n]) begin
        ident_cls = 6'(n);
      end
    end
  end

  always_comb begin
    mode_o   = mode_i;
    len_o    = len_i;
    acc_o    = acc_i;
    ovf_o    = ovf_i;
    pend_o   = pend_i;
    kw_we_o  = 1'b0;
    kw_idx_o = len_i[2:0];
    a_v      = 1'b0;
    b_v      = 1'b0;
    res_a    = '0;
    res_b    = '0;
    if (mode_i == ModeIdent && (let_c || dig_c)) begin
      if (len_room) begin
        kw_we_o = len_i < LenW'(KwChars);
        len_o   = len_i + LenW'(1);
      end else begin
        ovf_o = 1'b1;
      end
    end else if (mode_i == ModeNumber && dig_c) begin
      if (prod[ProdW-1:NUMBER_WIDTH] != '0) begin
        ovf_o = 1'b1;
      end
      acc_o = prod[NUMBER_WIDTH-1:0];
      if (len_room) begin
        len_o = len_i + LenW'(1);
      end
    end else if (mode_i == ModeOper && oper_pairs(pend_i, char_i)) begin
      a_v                = 1'b1;
      res_a.token_class  = oper_single(pend_i) + 6'd1;
      res_a.token_length = 5'd2;
      mode_o             = ModeIdle;
    end else begin
      case (mode_i)
        ModeIdent: begin
          a_v                = 1'b1;
          res_a.token_class  = ident_cls;
          res_a.token_length = len_ext[4:0];
          res_a.overflow     = ovf_i;
        end
        ModeNumber: begin
          a_v                = 1'b1;
          res_a.token_class  = ClsNumber;
          res_a.number_value = value_ext[31:0];
          res_a.token_length = len_ext[4:0];
          res_a.overflow     = ovf_i;
        end
        ModeOper: begin
          a_v                = 1'b1;
          res_a.token_class  = oper_single(pend_i);
          res_a.token_length = 5'd1;
        end
        default: begin
        end
      endcase
      mode_o = ModeIdle;
      if (char_i == " ") begin
        b_v = 1'b0;
      end else if (char_i == 8'h00) begin
        b_v               = 1'b1;
        res_b.token_class = ClsInvalid;
      end else if (let_c) begin
        mode_o   = ModeIdent;
        kw_we_o  = 1'b1;
        kw_idx_o = 3'd0;
        len_o    = LenW'(1);
        ovf_o    = 1'b0;
      end else if (dig_c) begin
        mode_o = ModeNumber;
        acc_o  = NUMBER_WIDTH'(digit);
        len_o  = LenW'(1);
        ovf_o  = 1'b0;
      end else if (two_capable(char_i)) begin
        mode_o = ModeOper;
        pend_o = char_i;
      end else begin
        b_v                = 1'b1;
        res_b.token_class  = oper_single(char_i);
        res_b.token_length = 5'd1;
      end
    end
  end

  always_comb begin
    pair_valid_o = a_v || b_v;
    pair_o.two   = a_v && b_v;
    pair_o.res0  = a_v ? res_a : res_b;
    pair_o.res1  = res_b;
    pair_o.res0.last_of_run = !(a_v && b_v);
    pair_o.res1.last_of_run = 1'b1;
  end

endmodule

[design/c_subset_lexical_scanner_unit.sv]
// ----------------------------------------------------------------------------
// c_subset_lexical_scanner_unit: streaming tokenizer for a small C subset
// Takes one character per word and emits token words through a two-entry
// queue of result pairs.
// A token word enters the result queue register when the character that ends it is accepted.
// Throughput: one character per cycle while results drain at one word per
// cycle; a character that yields two words is delivered as two successive words.
// Input ready drops only while both queue entries hold undelivered results.
// Reset clears the scan state and the queue; the keyword buffer is not reset.
// ----------------------------------------------------------------------------
module c_subset_lexical_scanner_unit #(
  parameter int unsigned MAX_TOKEN_LEN = cslex_pkg::MaxTokenLenDefault,
  parameter int unsigned NUMBER_WIDTH  = cslex_pkg::NumberWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_code
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] token_class, [37:6] number_value, [42:38] token_length,
  // [43] overflow, [47:44] zero
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import cslex_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN);

  logic [1:0]              mode_q, mode_d;
  logic [LenW-1:0]         len_q, len_d;
  logic [NUMBER_WIDTH-1:0] acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic [7:0]              pend_q, pend_d;
  logic [7:0]              kw_q [KwChars];
  logic                    kw_we;
  logic [2:0]              kw_idx;
  logic                    pair_valid;
  cslex_pair_t             pair;

  cslex_pair_t             queue_q [2];
  logic                    wr_ptr_q, rd_ptr_q, sub_q;
  logic [1:0]              cnt_q;
  logic                    in_fire, out_fire, push, pop;
  cslex_pair_t             head;
  cslex_res_t              out_res;

  cslex_step #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_step (
    .char_i      (s_axis_tdata_i),
    .mode_i      (mode_q),
    .len_i       (len_q),
    .acc_i       (acc_q),
    .ovf_i       (ovf_q),
    .pend_i      (pend_q),
    .kw_i        (kw_q),
    .mode_o      (mode_d),
    .len_o       (len_d),
    .acc_o       (acc_d),
    .ovf_o       (ovf_d),
    .pend_o      (pend_d),
    .kw_we_o     (kw_we),
    .kw_idx_o    (kw_idx),
    .pair_valid_o(pair_valid),
    .pair_o      (pair)
  );

  assign s_axis_tready_o = cnt_q != 2'd2;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = in_fire && pair_valid;
  assign head            = queue_q[rd_ptr_q];
  assign out_res         = sub_q ? head.res1 : head.res0;
  assign m_axis_tvalid_o = cnt_q != 2'd0;
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign pop             = out_fire && (sub_q || !head.two);
  assign m_axis_tdata_o  = {4'b0000, out_res.overflow, out_res.token_length,
                            out_res.number_value, out_res.token_class};
  assign m_axis_tlast_o  = out_res.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      len_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      pend_q <= '0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && kw_we) begin
      kw_q[kw_idx] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      sub_q    <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (out_fire) begin
        sub_q <= !pop;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_sub_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && sub_q) |-> head.two)
    else $error("second result offered from a single-result entry");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (sub_q || !head.two)) |-> m_axis_tlast_o)
    else $error("final word of a character lacks tlast");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_TOKEN_LEN - 1))
    else $error("token length beyond saturation limit");

  a_oper_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeOper) |-> two_capable(pend_q))
    else $error("pending operator cannot start a two-character operator");
`endif

endmodule
